### src/i2cm_pkg.sv
// Package for the I2C register-access master: phase codes, command codes,
// register indexes and default values. No dependencies.
package i2cm_pkg;

   localparam int BufferDepthDefault = 16;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam logic [1:0] CSR_RETRY_WAIT  = 2'd0;
   localparam logic [1:0] CSR_RETRY_LIMIT = 2'd1;
   localparam logic [1:0] CSR_ACK_TIMEOUT = 2'd2;

   localparam logic [15:0] RETRY_WAIT_RESET  = 16'd5;
   localparam logic [2:0]  RETRY_LIMIT_RESET = 3'd5;
   localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

   typedef enum logic [1:0] {
      K_ADDR_W = 2'd0, K_REG = 2'd1, K_DATA = 2'd2, K_ADDR_R = 2'd3
   } kind_type;

   typedef enum logic [22:0] {
      PH_IDLE       = 23'd1 << 0,
      PH_S1         = 23'd1 << 1,
      PH_S2         = 23'd1 << 2,
      PH_S3         = 23'd1 << 3,
      PH_S4         = 23'd1 << 4,
      PH_TX_SDA     = 23'd1 << 5,
      PH_TX_SCLH    = 23'd1 << 6,
      PH_TX_SCLL    = 23'd1 << 7,
      PH_ACK_REL    = 23'd1 << 8,
      PH_ACK_SCLH   = 23'd1 << 9,
      PH_ACK_SAMPLE = 23'd1 << 10,
      PH_RX_PREP    = 23'd1 << 11,
      PH_RX_SCLH    = 23'd1 << 12,
      PH_RX_SAMPLE  = 23'd1 << 13,
      PH_RA_SDA     = 23'd1 << 14,
      PH_RA_SCLH    = 23'd1 << 15,
      PH_RA_SCLL    = 23'd1 << 16,
      PH_P1         = 23'd1 << 17,
      PH_P2         = 23'd1 << 18,
      PH_P3         = 23'd1 << 19,
      PH_EP2        = 23'd1 << 20,
      PH_EP3        = 23'd1 << 21,
      PH_WAIT       = 23'd1 << 22
   } phase_type;

   // buffer read request from the sequencer to the buffer
   typedef struct packed {
      logic       rd;
      logic [7:0] idx;
   } buf_rd_type;

endpackage

### src/i2c_master_register_access.sv
// Top level of the I2C register-access master: sequencer plus write buffer.
// Depends on i2cm_pkg and i2cm_wbuf.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_tvalid/tready    | tuser=command, tdata=sda,dev,reg,cnt,byte
//   rsp     | out | rsp_tvalid/tready    | tlast=last_read, tdata=other results
//   csr     | in  | csr_wr_en            | csr_index, csr_wdata
//
// One word per cycle: every request word yields one response word in the next
// cycle. The write buffer is a memory with registered read data; the byte
// for the next data phase is prefetched while the ack is sampled, so no tick
// waits. Reset is synchronous and clears all control state; buffer contents are
// undefined until loaded. The response register holds while rsp_tready is low;
// req_tready then drops, so a stalled output stalls the input.
module i2c_master_register_access #(
   parameter int BUFFER_DEPTH = i2cm_pkg::BufferDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // command
   input  logic [31:0] req_tdata,   // sda_in, device_address, register_address,
                                    // byte_count, data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tlast,   // last_read
   output logic [15:0] rsp_tdata,   // scl_out, sda_out, read_valid, read_byte,
                                    // busy_res, done_res, status
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int PW = $clog2(BUFFER_DEPTH + 1);

   // unpack request word
   logic [1:0] cmd;
   logic       sda_in;
   logic [6:0] dev_in;
   logic [7:0] reg_in, cnt_in, byte_in;
   assign cmd     = req_tuser;
   assign sda_in  = req_tdata[0];
   assign dev_in  = req_tdata[7:1];
   assign reg_in  = req_tdata[15:8];
   assign cnt_in  = req_tdata[23:16];
   assign byte_in = req_tdata[31:24];

   // configuration
   logic [15:0] retry_wait_ff;
   logic [2:0]  retry_limit_ff;
   logic [7:0]  ack_timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_wait_ff  <= i2cm_pkg::RETRY_WAIT_RESET;
         retry_limit_ff <= i2cm_pkg::RETRY_LIMIT_RESET;
         ack_timeout_ff <= i2cm_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            i2cm_pkg::CSR_RETRY_WAIT:  retry_wait_ff  <= csr_wdata;
            i2cm_pkg::CSR_RETRY_LIMIT: retry_limit_ff <= csr_wdata[2:0];
            i2cm_pkg::CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // sequencer state
   i2cm_pkg::phase_type phase_ff, phase_in;
   i2cm_pkg::kind_type  kind_ff, kind_in;
   logic [3:0]  bitc_ff, bitc_in;
   logic [7:0]  shreg_ff, shreg_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  ackw_ff, ackw_in;
   logic [2:0]  retry_ff, retry_in;
   logic [15:0] wait_ff, wait_in;
   logic [PW-1:0] lptr_ff, lptr_in;
   logic [6:0]  dev_ff, dev_in_r;
   logic [7:0]  reg_ff, reg_in_r;
   logic [7:0]  cnt_ff, cnt_in_r;
   logic        isrd_ff, isrd_in;
   logic        scl_ff, scl_in, sda_ff, sda_in_r;

   // response register
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   logic acc;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign acc = req_tvalid && req_tready;

   // buffer ports
   logic                 wr_en;
   logic [7:0]           rd_data;
   i2cm_pkg::buf_rd_type rd_req;

   i2cm_wbuf #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_wbuf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (lptr_ff[AW-1:0]),
      .wr_data (byte_in),
      .rd_req  (rd_req),
      .rd_data (rd_data)
   );

   // Prefetch: the data byte index is cnt - left; while the next phase may
   // consume a data byte (ack sample ahead of a data load), read it now.
   // In the ack phase, left is decremented for DATA before loading.
   logic [7:0] idx_now, idx_next;
   assign idx_now  = cnt_ff - left_ff;
   assign idx_next = cnt_ff - left_ff + 8'd1;
   assign rd_req.rd  = acc && (phase_ff == i2cm_pkg::PH_ACK_SAMPLE);
   assign rd_req.idx = (kind_ff == i2cm_pkg::K_DATA) ? idx_next : idx_now;

   // the prefetched byte is valid only if the index lies inside the buffer
   logic pf_ok_ff;
   always_ff @(posedge clock) begin
      if (rd_req.rd) begin
         pf_ok_ff <= {8'd0, rd_req.idx} < 16'(BUFFER_DEPTH);
      end
   end
   logic [7:0] data_byte_rd;
   assign data_byte_rd = pf_ok_ff ? rd_data : 8'd0;

   // a data byte enters the shift register in the cycle after the ack sample
   logic       load_pf_ff;
   logic [7:0] shreg_eff;
   assign shreg_eff = load_pf_ff ? data_byte_rd : shreg_ff;

   logic ph_idle;
   assign ph_idle = (phase_ff == i2cm_pkg::PH_IDLE);
   assign wr_en = acc && ph_idle && (cmd == i2cm_pkg::CMD_LOAD)
                  && ({{(32-PW){1'b0}}, lptr_ff} < 32'(BUFFER_DEPTH));

   logic       rv, last, done, st;
   logic [7:0] rb;
   logic [7:0] left_dec;
   logic [3:0] bitc_dec;

   always_comb begin
      phase_in = phase_ff;  kind_in = kind_ff;   bitc_in = bitc_ff;
      shreg_in = shreg_eff; left_in = left_ff;   ackw_in = ackw_ff;
      retry_in = retry_ff;  wait_in = wait_ff;   lptr_in = lptr_ff;
      dev_in_r = dev_ff;    reg_in_r = reg_ff;   cnt_in_r = cnt_ff;
      isrd_in  = isrd_ff;   scl_in = scl_ff;     sda_in_r = sda_ff;
      rv = 1'b0; rb = 8'd0; last = 1'b0; done = 1'b0; st = 1'b0;
      left_dec = left_ff - 8'd1;
      bitc_dec = bitc_ff - 4'd1;
      if (cmd != i2cm_pkg::CMD_TICK) begin
         if (ph_idle) begin
            if (cmd == i2cm_pkg::CMD_LOAD) begin
               if (wr_en) lptr_in = lptr_ff + PW'(1);
            end else begin
               isrd_in = (cmd == i2cm_pkg::CMD_READ);
               cnt_in_r = cnt_in;
               if (cmd == i2cm_pkg::CMD_WRITE) begin
                  if ({8'd0, cnt_in} > 16'(BUFFER_DEPTH)) cnt_in_r = 8'(BUFFER_DEPTH);
                  lptr_in = '0;
               end
               dev_in_r = dev_in;
               reg_in_r = reg_in;
               retry_in = '0;
               kind_in  = i2cm_pkg::K_ADDR_W;
               left_in  = cnt_in_r;
               phase_in = i2cm_pkg::PH_S1;
            end
         end
      end else begin
         case (phase_ff)
            i2cm_pkg::PH_S1: begin sda_in_r = 1'b1; phase_in = i2cm_pkg::PH_S2; end
            i2cm_pkg::PH_S2: begin scl_in = 1'b1; phase_in = i2cm_pkg::PH_S3; end
            i2cm_pkg::PH_S3: begin sda_in_r = 1'b0; phase_in = i2cm_pkg::PH_S4; end
            i2cm_pkg::PH_S4: begin
               scl_in = 1'b0;
               shreg_in = {dev_ff, kind_ff == i2cm_pkg::K_ADDR_R};
               bitc_in = 4'd8;
               phase_in = i2cm_pkg::PH_TX_SDA;
            end
            i2cm_pkg::PH_TX_SDA: begin
               sda_in_r = shreg_eff[7];
               shreg_in = {shreg_eff[6:0], 1'b0};
               phase_in = i2cm_pkg::PH_TX_SCLH;
            end
            i2cm_pkg::PH_TX_SCLH: begin scl_in = 1'b1; phase_in = i2cm_pkg::PH_TX_SCLL; end
            i2cm_pkg::PH_TX_SCLL: begin
               scl_in = 1'b0;
               bitc_in = bitc_dec;
               phase_in = (bitc_dec != 4'd0) ? i2cm_pkg::PH_TX_SDA : i2cm_pkg::PH_ACK_REL;
            end
            i2cm_pkg::PH_ACK_REL: begin
               sda_in_r = 1'b1; ackw_in = '0; phase_in = i2cm_pkg::PH_ACK_SCLH;
            end
            i2cm_pkg::PH_ACK_SCLH: begin scl_in = 1'b1; phase_in = i2cm_pkg::PH_ACK_SAMPLE; end
            i2cm_pkg::PH_ACK_SAMPLE: begin
               if (!sda_in) begin
                  scl_in = 1'b0;
                  // the data byte itself arrives next cycle from the buffer
                  case (kind_ff)
                     i2cm_pkg::K_ADDR_W: begin
                        kind_in = i2cm_pkg::K_REG;
                        shreg_in = reg_ff; bitc_in = 4'd8;
                        phase_in = i2cm_pkg::PH_TX_SDA;
                     end
                     i2cm_pkg::K_REG: begin
                        if (isrd_ff) begin
                           kind_in = i2cm_pkg::K_ADDR_R; phase_in = i2cm_pkg::PH_S1;
                        end else if (left_ff != 8'd0) begin
                           kind_in = i2cm_pkg::K_DATA; bitc_in = 4'd8;
                           phase_in = i2cm_pkg::PH_TX_SDA;
                        end else begin
                           phase_in = i2cm_pkg::PH_P1;
                        end
                     end
                     i2cm_pkg::K_DATA: begin
                        left_in = left_dec;
                        if (left_dec != 8'd0) begin
                           bitc_in = 4'd8; phase_in = i2cm_pkg::PH_TX_SDA;
                        end else begin
                           phase_in = i2cm_pkg::PH_P1;
                        end
                     end
                     default: begin
                        phase_in = (left_ff != 8'd0) ? i2cm_pkg::PH_RX_PREP
                                                     : i2cm_pkg::PH_P1;
                     end
                  endcase
               end else if (ackw_ff >= ack_timeout_ff) begin
                  sda_in_r = 1'b0; phase_in = i2cm_pkg::PH_EP2;
               end else begin
                  ackw_in = ackw_ff + 8'd1;
               end
            end
            i2cm_pkg::PH_RX_PREP: begin
               sda_in_r = 1'b1; scl_in = 1'b0; shreg_in = '0; bitc_in = 4'd8;
               phase_in = i2cm_pkg::PH_RX_SCLH;
            end
            i2cm_pkg::PH_RX_SCLH: begin scl_in = 1'b1; phase_in = i2cm_pkg::PH_RX_SAMPLE; end
            i2cm_pkg::PH_RX_SAMPLE: begin
               shreg_in = {shreg_ff[6:0], sda_in};
               scl_in = 1'b0;
               bitc_in = bitc_dec;
               if (bitc_dec != 4'd0) begin
                  phase_in = i2cm_pkg::PH_RX_SCLH;
               end else begin
                  rv = 1'b1; rb = shreg_in; last = (left_ff == 8'd1);
                  phase_in = i2cm_pkg::PH_RA_SDA;
               end
            end
            i2cm_pkg::PH_RA_SDA: begin
               sda_in_r = (left_ff == 8'd1); phase_in = i2cm_pkg::PH_RA_SCLH;
            end
            i2cm_pkg::PH_RA_SCLH: begin scl_in = 1'b1; phase_in = i2cm_pkg::PH_RA_SCLL; end
            i2cm_pkg::PH_RA_SCLL: begin
               scl_in = 1'b0; left_in = left_dec;
               phase_in = (left_dec != 8'd0) ? i2cm_pkg::PH_RX_PREP : i2cm_pkg::PH_P1;
            end
            i2cm_pkg::PH_P1: begin sda_in_r = 1'b0; phase_in = i2cm_pkg::PH_P2; end
            i2cm_pkg::PH_P2: begin scl_in = 1'b1; phase_in = i2cm_pkg::PH_P3; end
            i2cm_pkg::PH_P3: begin
               sda_in_r = 1'b1; done = 1'b1; phase_in = i2cm_pkg::PH_IDLE;
            end
            i2cm_pkg::PH_EP2: begin scl_in = 1'b1; phase_in = i2cm_pkg::PH_EP3; end
            i2cm_pkg::PH_EP3: begin
               sda_in_r = 1'b1;
               if (retry_wait_ff != 16'd0 && retry_ff < retry_limit_ff) begin
                  retry_in = retry_ff + 3'd1;
                  wait_in = retry_wait_ff;
                  phase_in = i2cm_pkg::PH_WAIT;
               end else begin
                  done = 1'b1; st = 1'b1; phase_in = i2cm_pkg::PH_IDLE;
               end
            end
            i2cm_pkg::PH_WAIT: begin
               wait_in = wait_ff - 16'd1;
               if (wait_in == 16'd0) begin
                  kind_in = i2cm_pkg::K_ADDR_W; left_in = cnt_ff;
                  phase_in = i2cm_pkg::PH_S1;
               end
            end
            default: phase_in = i2cm_pkg::PH_IDLE;
         endcase
      end
      rsp_data_in = {2'b00, st, done, phase_in != i2cm_pkg::PH_IDLE, rb, rv,
                     sda_in_r, scl_in};
      rsp_last_in = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cm_pkg::PH_IDLE; kind_ff <= i2cm_pkg::K_ADDR_W;
         bitc_ff <= '0; shreg_ff <= '0; left_ff <= '0; ackw_ff <= '0;
         retry_ff <= '0; wait_ff <= '0; lptr_ff <= '0;
         dev_ff <= '0; reg_ff <= '0; cnt_ff <= '0; isrd_ff <= 1'b0;
         scl_ff <= 1'b1; sda_ff <= 1'b1;
         rsp_valid_ff <= 1'b0; load_pf_ff <= 1'b0;
      end else begin
         if (acc) begin
            phase_ff <= phase_in; kind_ff <= kind_in; bitc_ff <= bitc_in;
            shreg_ff <= shreg_in; left_ff <= left_in; ackw_ff <= ackw_in;
            retry_ff <= retry_in; wait_ff <= wait_in; lptr_ff <= lptr_in;
            dev_ff <= dev_in_r; reg_ff <= reg_in_r; cnt_ff <= cnt_in_r;
            isrd_ff <= isrd_in; scl_ff <= scl_in; sda_ff <= sda_in_r;
            load_pf_ff <= rd_req.rd && !sda_in && kind_in == i2cm_pkg::K_DATA
                          && phase_in == i2cm_pkg::PH_TX_SDA;
         end else begin
            // hold the prefetched byte while the input stalls
            load_pf_ff <= 1'b0;
            if (load_pf_ff) begin
               shreg_ff <= data_byte_rd;
            end
         end
         if (acc) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule

### src/i2cm_wbuf.sv
// Write-byte buffer: one synchronous memory, one write port, one read port
// with registered read data. Depends on i2cm_pkg.
module i2cm_wbuf #(
   parameter int BUFFER_DEPTH = i2cm_pkg::BufferDepthDefault,
   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [7:0]           wr_data,
   input  i2cm_pkg::buf_rd_type rd_req,
   output logic [7:0]           rd_data
);
   logic [7:0] mem [BUFFER_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_req.rd) begin
         rd_data_ff <= mem[rd_req.idx[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
